// ===== src/bptc_pkg.sv =====
// shared types, constants and helpers for the baro compensation pipeline
package bptc_pkg;

  localparam int NumStages = 17;

  localparam int CfgDataWidth = 48;
  localparam int CfgIndexWidth = 2;

  localparam logic signed [16:0] CalibOffset = 17'sd16384;
  localparam logic signed [5:0] TempScale = 6'sd25;
  localparam logic [4:0] PressScale = 5'd25;

  localparam logic signed [15:0] TempMax = 16'sh7FFF;
  localparam logic signed [15:0] TempMin = 16'sh8000;
  localparam logic [23:0] PressMax = 24'hFFFFFF;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgTempCalib   = 2'd0,
    CfgPressCalibA = 2'd1,
    CfgPressCalibB = 2'd2,
    CfgPressCalibC = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } bptc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centideg;
    logic [23:0]        pressure_centipascal;
  } bptc_out_t;

  // signed divide by 2^k, rounding toward zero
  function automatic logic signed [63:0] sar_trunc(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ===== src/baro_pressure_temp_compensation_unit.sv =====
// compensation of raw pressure and temperature readings, deep pipeline
//
// Requests enter on in_valid_i / in_stall_o with in_data_i holding one raw
// pressure and one raw temperature reading. Results leave on out_valid_o /
// out_stall_i with out_data_o holding temperature in 0.01 degC and pressure
// in 0.01 Pa. Calibration coefficients are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write them only while no request is in
// flight, which the block itself does not enforce. The datapath is a 17-stage
// pipeline of multipliers and 64-bit adders, with the multiplications and wide adds
// spread over the stages. One request is taken every cycle while in_stall_o is low.
// Reset clears the calibration registers to zero and empties the pipeline.
// When the receiver stalls, the last stage holds its result while earlier
// stages keep moving into empty slots; in_stall_o rises only once every stage
// holds a request.
module baro_pressure_temp_compensation_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  bptc_pkg::bptc_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output bptc_pkg::bptc_out_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [bptc_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [bptc_pkg::CfgDataWidth-1:0]     cfg_data_i
);

  // calibration registers
  logic [39:0] temp_calib_q;
  logic [47:0] press_calib_a_q;
  logic [47:0] press_calib_b_q;
  logic [31:0] press_calib_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q    <= '0;
      press_calib_a_q <= '0;
      press_calib_b_q <= '0;
      press_calib_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (bptc_pkg::cfg_idx_e'(cfg_index_i))
        bptc_pkg::CfgTempCalib:   temp_calib_q    <= cfg_data_i[39:0];
        bptc_pkg::CfgPressCalibA: press_calib_a_q <= cfg_data_i[47:0];
        bptc_pkg::CfgPressCalibB: press_calib_b_q <= cfg_data_i[47:0];
        bptc_pkg::CfgPressCalibC: press_calib_c_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1;
  logic signed [16:0] t2_s;
  logic signed [7:0]  t3;
  logic signed [16:0] p1_m;
  logic signed [16:0] p2_m;
  logic signed [7:0]  p3;
  logic signed [7:0]  p4;
  logic [15:0]        p5;
  logic signed [16:0] p6_s;
  logic signed [7:0]  p7;
  logic signed [7:0]  p8;
  logic signed [15:0] p9;
  logic signed [7:0]  p10;
  logic signed [7:0]  p11;

  assign t1   = temp_calib_q[15:0];
  assign t2_s = $signed({1'b0, temp_calib_q[31:16]});
  assign t3   = $signed(temp_calib_q[39:32]);
  assign p1_m = 17'($signed(press_calib_a_q[15:0])) - bptc_pkg::CalibOffset;
  assign p2_m = 17'($signed(press_calib_a_q[31:16])) - bptc_pkg::CalibOffset;
  assign p3   = $signed(press_calib_a_q[39:32]);
  assign p4   = $signed(press_calib_a_q[47:40]);
  assign p5   = press_calib_b_q[15:0];
  assign p6_s = $signed({1'b0, press_calib_b_q[31:16]});
  assign p7   = $signed(press_calib_b_q[39:32]);
  assign p8   = $signed(press_calib_b_q[47:40]);
  assign p9   = $signed(press_calib_c_q[15:0]);
  assign p10  = $signed(press_calib_c_q[23:16]);
  assign p11  = $signed(press_calib_c_q[31:24]);

  // stage handshake: a stage loads when it is empty or the next one moves
  logic [bptc_pkg::NumStages:1]   valid_q;
  logic [bptc_pkg::NumStages:1]   valid_in;
  logic [bptc_pkg::NumStages+1:1] ready;

  assign valid_in = {valid_q[bptc_pkg::NumStages-1:1], in_valid_i};

  always_comb begin
    ready[bptc_pkg::NumStages+1] = !out_stall_i;
    for (int k = bptc_pkg::NumStages; k >= 1; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 1; k <= bptc_pkg::NumStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  assign in_stall_o  = !ready[1];
  assign out_valid_o = valid_q[bptc_pkg::NumStages];

  // stage 1: temperature difference
  logic signed [25:0] d_d;
  logic signed [24:0] s1_d_q;
  logic [23:0]        s1_rp_q;

  assign d_d = $signed({2'b00, in_data_i.raw_temperature}) - $signed({2'b00, t1, 8'h00});

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      s1_d_q  <= d_d[24:0];
      s1_rp_q <= in_data_i.raw_pressure;
    end
  end

  // stage 2: t2*d and d*d
  logic signed [49:0] dd_d;
  logic signed [40:0] s2_td_q;
  logic [47:0]        s2_dd_q;
  logic [23:0]        s2_rp_q;

  assign dd_d = 50'(s1_d_q) * 50'(s1_d_q);

  always_ff @(posedge clk_i) begin
    if (ready[2]) begin
      s2_td_q <= 41'(t2_s) * 41'(s1_d_q);
      s2_dd_q <= dd_d[47:0];
      s2_rp_q <= s1_rp_q;
    end
  end

  // stage 3: d*d*t3
  logic signed [40:0] s3_td_q;
  logic signed [55:0] s3_ddt_q;
  logic [23:0]        s3_rp_q;

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      s3_td_q  <= s2_td_q;
      s3_ddt_q <= 56'(t3) * 56'($signed({1'b0, s2_dd_q}));
      s3_rp_q  <= s2_rp_q;
    end
  end

  // stage 4: linearisation sum
  logic signed [59:0] s4_tsum_q;
  logic [23:0]        s4_rp_q;

  always_ff @(posedge clk_i) begin
    if (ready[4]) begin
      s4_tsum_q <= 60'($signed({s3_td_q, 18'h00000})) + 60'(s3_ddt_q);
      s4_rp_q   <= s3_rp_q;
    end
  end

  // stage 5: t_lin
  logic signed [63:0] tl_d;
  logic signed [27:0] s5_tl_q;
  logic [23:0]        s5_rp_q;

  assign tl_d = bptc_pkg::sar_trunc(64'(s4_tsum_q), 32);

  always_ff @(posedge clk_i) begin
    if (ready[5]) begin
      s5_tl_q <= tl_d[27:0];
      s5_rp_q <= s4_rp_q;
    end
  end

  // stage 6: products of t_lin
  logic signed [55:0] tt_d;
  logic signed [44:0] g_d;
  logic signed [44:0] fs_d;
  logic [53:0]        s6_tt_q;
  logic signed [32:0] s6_t25_q;
  logic [41:0]        s6_g_q;
  logic [42:0]        s6_fs_q;
  logic signed [34:0] s6_pt10_q;
  logic signed [27:0] s6_tl_q;
  logic [23:0]        s6_rp_q;

  assign tt_d = 56'(s5_tl_q) * 56'(s5_tl_q);
  assign g_d  = 45'(p6_s) * 45'(s5_tl_q);
  assign fs_d = 45'(p2_m) * 45'(s5_tl_q);

  always_ff @(posedge clk_i) begin
    if (ready[6]) begin
      s6_tt_q   <= tt_d[53:0];
      s6_t25_q  <= 33'(s5_tl_q) * 33'(bptc_pkg::TempScale);
      s6_g_q    <= g_d[41:0];
      s6_fs_q   <= fs_d[42:0];
      s6_pt10_q <= 35'(p10) * 35'(s5_tl_q);
      s6_tl_q   <= s5_tl_q;
      s6_rp_q   <= s5_rp_q;
    end
  end

  // stage 7: cube halves, square terms, temperature result
  logic signed [63:0] tq_d;
  logic signed [19:0] tq20;
  logic signed [15:0] temp_d;
  logic signed [52:0] s7_bhp_q;
  logic signed [52:0] s7_blp_q;
  logic signed [61:0] s7_fo_q;
  logic signed [61:0] s7_es_q;
  logic signed [15:0] s7_temp_q;
  logic signed [35:0] s7_cp_q;
  logic [47:0]        s7_gp_q;
  logic [41:0]        s7_g_q;
  logic [42:0]        s7_fs_q;
  logic [23:0]        s7_rp_q;

  assign tq_d = bptc_pkg::sar_trunc(64'(s6_t25_q), 14);
  assign tq20 = tq_d[19:0];

  always_comb begin
    priority if (tq20 > 20'(bptc_pkg::TempMax)) begin
      temp_d = bptc_pkg::TempMax;
    end else if (tq20 < 20'(bptc_pkg::TempMin)) begin
      temp_d = bptc_pkg::TempMin;
    end else begin
      temp_d = tq20[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[7]) begin
      // (tt >> 6) * t_lin split into two 24-bit halves
      s7_bhp_q  <= 53'($signed({1'b0, s6_tt_q[53:30]})) * 53'(s6_tl_q);
      s7_blp_q  <= 53'($signed({1'b0, s6_tt_q[29:6]})) * 53'(s6_tl_q);
      s7_fo_q   <= 62'(p7) * 62'($signed({1'b0, s6_tt_q}));
      s7_es_q   <= 62'(p3) * 62'($signed({1'b0, s6_tt_q}));
      s7_temp_q <= temp_d;
      s7_cp_q   <= 36'(s6_pt10_q) + 36'($signed({p9, 16'h0000}));
      s7_gp_q   <= 48'(s6_rp_q) * 48'(s6_rp_q);
      s7_g_q    <= s6_g_q;
      s7_fs_q   <= s6_fs_q;
      s7_rp_q   <= s6_rp_q;
    end
  end

  // stage 8: cube recombined, pressure partial products
  logic [63:0]        s8_cprod_q;
  logic signed [59:0] s8_ep_q;
  logic signed [56:0] s8_bp_q;
  logic signed [61:0] s8_fo_q;
  logic signed [61:0] s8_es_q;
  logic [41:0]        s8_g_q;
  logic [42:0]        s8_fs_q;
  logic signed [15:0] s8_temp_q;
  logic [23:0]        s8_rp_q;

  always_ff @(posedge clk_i) begin
    if (ready[8]) begin
      s8_cprod_q <= {s7_bhp_q[39:0], 24'h000000} + 64'(s7_blp_q);
      s8_ep_q    <= 60'(s7_cp_q) * 60'($signed({1'b0, s7_rp_q}));
      s8_bp_q    <= 57'(p11) * 57'($signed({1'b0, s7_gp_q}));
      s8_fo_q    <= s7_fo_q;
      s8_es_q    <= s7_es_q;
      s8_g_q     <= s7_g_q;
      s8_fs_q    <= s7_fs_q;
      s8_temp_q  <= s7_temp_q;
      s8_rp_q    <= s7_rp_q;
    end
  end

  // stage 9: scaling shifts
  logic signed [63:0] c_d;
  logic signed [63:0] ep_d;
  logic signed [63:0] bp_d;
  logic signed [55:0] s9_c_q;
  logic signed [46:0] s9_ep_q;
  logic signed [40:0] s9_bp_q;
  logic signed [61:0] s9_fo_q;
  logic signed [61:0] s9_es_q;
  logic [41:0]        s9_g_q;
  logic [42:0]        s9_fs_q;
  logic signed [15:0] s9_temp_q;
  logic [23:0]        s9_rp_q;

  assign c_d  = bptc_pkg::sar_trunc($signed(s8_cprod_q), 8);
  assign ep_d = bptc_pkg::sar_trunc(64'(s8_ep_q), 13);
  assign bp_d = bptc_pkg::sar_trunc(64'(s8_bp_q), 16);

  always_ff @(posedge clk_i) begin
    if (ready[9]) begin
      s9_c_q    <= c_d[55:0];
      s9_ep_q   <= ep_d[46:0];
      s9_bp_q   <= bp_d[40:0];
      s9_fo_q   <= s8_fo_q;
      s9_es_q   <= s8_es_q;
      s9_g_q    <= s8_g_q;
      s9_fs_q   <= s8_fs_q;
      s9_temp_q <= s8_temp_q;
      s9_rp_q   <= s8_rp_q;
    end
  end

  // stage 10: cube coefficients, pressure products against the raw reading
  logic signed [63:0] s10_ec_q;
  logic signed [63:0] s10_bc_q;
  logic signed [59:0] s10_fl_q;
  logic signed [59:0] s10_fh_q;
  logic signed [63:0] s10_c2_q;
  logic signed [61:0] s10_fo_q;
  logic signed [61:0] s10_es_q;
  logic [41:0]        s10_g_q;
  logic [42:0]        s10_fs_q;
  logic signed [15:0] s10_temp_q;
  logic [23:0]        s10_rp_q;

  always_ff @(posedge clk_i) begin
    if (ready[10]) begin
      s10_ec_q   <= 64'(p8) * 64'(s9_c_q);
      s10_bc_q   <= 64'(p4) * 64'(s9_c_q);
      s10_fl_q   <= 60'(s9_ep_q) * 60'($signed({1'b0, s9_rp_q[11:0]}));
      s10_fh_q   <= 60'(s9_ep_q) * 60'($signed({1'b0, s9_rp_q[23:12]}));
      s10_c2_q   <= 64'(s9_bp_q) * 64'($signed({1'b0, s9_rp_q}));
      s10_fo_q   <= s9_fo_q;
      s10_es_q   <= s9_es_q;
      s10_g_q    <= s9_g_q;
      s10_fs_q   <= s9_fs_q;
      s10_temp_q <= s9_temp_q;
      s10_rp_q   <= s9_rp_q;
    end
  end

  // stage 11: shifts and first pairs of the offset and sensitivity sums
  logic signed [63:0] eo_d;
  logic signed [63:0] bs_d;
  logic signed [63:0] c2_d;
  logic signed [58:0] s11_eo_q;
  logic signed [58:0] s11_bs_q;
  logic [63:0]        s11_fp_q;
  logic signed [56:0] s11_c2_q;
  logic [63:0]        s11_oa_q;
  logic [63:0]        s11_sa_q;
  logic signed [61:0] s11_fo_q;
  logic signed [61:0] s11_es_q;
  logic signed [15:0] s11_temp_q;
  logic [23:0]        s11_rp_q;

  assign eo_d = bptc_pkg::sar_trunc(s10_ec_q, 5);
  assign bs_d = bptc_pkg::sar_trunc(s10_bc_q, 5);
  assign c2_d = bptc_pkg::sar_trunc(s10_c2_q, 7);

  always_ff @(posedge clk_i) begin
    if (ready[11]) begin
      s11_eo_q   <= eo_d[58:0];
      s11_bs_q   <= bs_d[58:0];
      s11_fp_q   <= {s10_fh_q[51:0], 12'h000} + 64'(s10_fl_q);
      s11_c2_q   <= c2_d[56:0];
      s11_oa_q   <= {1'b0, p5, 47'h0} + {s10_g_q, 22'h000000};
      s11_sa_q   <= 64'($signed({p1_m, 46'h0})) + {s10_fs_q, 21'h000000};
      s11_fo_q   <= s10_fo_q;
      s11_es_q   <= s10_es_q;
      s11_temp_q <= s10_temp_q;
      s11_rp_q   <= s10_rp_q;
    end
  end

  // stage 12: offset and sensitivity
  logic signed [63:0] fp_d;
  logic [63:0]        s12_off_q;
  logic [63:0]        s12_sens_q;
  logic signed [54:0] s12_fp_q;
  logic signed [56:0] s12_c2_q;
  logic signed [15:0] s12_temp_q;
  logic [23:0]        s12_rp_q;

  assign fp_d = bptc_pkg::sar_trunc($signed(s11_fp_q), 9);

  always_ff @(posedge clk_i) begin
    if (ready[12]) begin
      s12_off_q  <= s11_oa_q + 64'(s11_eo_q) + {s11_fo_q[59:0], 4'h0};
      s12_sens_q <= s11_sa_q + 64'(s11_bs_q) + {s11_es_q, 2'b00};
      s12_fp_q   <= fp_d[54:0];
      s12_c2_q   <= s11_c2_q;
      s12_temp_q <= s11_temp_q;
      s12_rp_q   <= s11_rp_q;
    end
  end

  // stage 13: offset/4 and sensitivity/2^24
  logic signed [63:0] off4_d;
  logic signed [63:0] s24_d;
  logic signed [61:0] s13_off4_q;
  logic signed [39:0] s13_s24_q;
  logic signed [54:0] s13_fp_q;
  logic signed [56:0] s13_c2_q;
  logic signed [15:0] s13_temp_q;
  logic [23:0]        s13_rp_q;

  assign off4_d = bptc_pkg::sar_trunc($signed(s12_off_q), 2);
  assign s24_d  = bptc_pkg::sar_trunc($signed(s12_sens_q), 24);

  always_ff @(posedge clk_i) begin
    if (ready[13]) begin
      s13_off4_q <= off4_d[61:0];
      s13_s24_q  <= s24_d[39:0];
      s13_fp_q   <= s12_fp_q;
      s13_c2_q   <= s12_c2_q;
      s13_temp_q <= s12_temp_q;
      s13_rp_q   <= s12_rp_q;
    end
  end

  // stage 14: sensitivity term and three-way partial sum
  logic [63:0]        s14_ap_q;
  logic [63:0]        s14_pp_q;
  logic signed [15:0] s14_temp_q;

  always_ff @(posedge clk_i) begin
    if (ready[14]) begin
      s14_ap_q   <= 64'(s13_s24_q) * 64'($signed({1'b0, s13_rp_q}));
      s14_pp_q   <= 64'(s13_off4_q) + 64'(s13_fp_q) + 64'(s13_c2_q);
      s14_temp_q <= s13_temp_q;
    end
  end

  // stage 15: pressure sum
  logic [63:0]        s15_sum_q;
  logic signed [15:0] s15_temp_q;

  always_ff @(posedge clk_i) begin
    if (ready[15]) begin
      s15_sum_q  <= s14_pp_q + s14_ap_q;
      s15_temp_q <= s14_temp_q;
    end
  end

  // stage 16: sum*25/2^40
  logic [67:0]        p25_d;
  logic               s16_pos_q;
  logic [27:0]        s16_p25_q;
  logic signed [15:0] s16_temp_q;

  assign p25_d = 68'(s15_sum_q[62:0]) * 68'(bptc_pkg::PressScale);

  always_ff @(posedge clk_i) begin
    if (ready[16]) begin
      s16_pos_q  <= !s15_sum_q[63] && (s15_sum_q != '0);
      s16_p25_q  <= p25_d[67:40];
      s16_temp_q <= s15_temp_q;
    end
  end

  // stage 17: clamp, output register
  logic [23:0]        press_d;
  logic [23:0]        s17_press_q;
  logic signed [15:0] s17_temp_q;

  always_comb begin
    priority if (!s16_pos_q) begin
      press_d = '0;
    end else if (|s16_p25_q[27:24]) begin
      press_d = bptc_pkg::PressMax;
    end else begin
      press_d = s16_p25_q[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[17]) begin
      s17_press_q <= press_d;
      s17_temp_q  <= s16_temp_q;
    end
  end

  assign out_data_o.temperature_centideg = s17_temp_q;
  assign out_data_o.pressure_centipascal = s17_press_q;

  // input backs up only when every stage holds a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while the pipeline has an empty stage");

  // requests in flight change only by acceptances and deliveries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (int'($countones(valid_q)) ==
      int'($past($countones(valid_q))) + int'($past(in_valid_i && !in_stall_o))
      - int'($past(out_valid_o && !out_stall_i))))
    else $error("request lost or duplicated in the pipeline");

endmodule

// ===== dv/baro_pressure_temp_compensation_unit_tb.sv =====
// self-checking bench for the compensation pipeline: directed table, then phases of random readings
module baro_pressure_temp_compensation_unit_tb;
  import bptc_pkg::*;

  localparam int NumPhases = 10;
  localparam int ItemsPerPhase = 80;
  localparam int NumDirSteps = 33;
  localparam int CycleLimit = 200000;

  typedef logic signed [63:0] s64_t;

  typedef enum logic {StepCfg, StepReq} step_kind_e;
  typedef enum int {CalSensor, CalRandom, CalOnes, CalZeros, CalSignedMax} cal_style_e;

  typedef struct {
    step_kind_e  kind;
    cfg_idx_e    reg_idx;
    logic [47:0] value;
    bptc_in_t    req;
    logic        known;
    bptc_out_t   res;
  } dir_step_t;

  typedef struct packed {
    logic      known;
    bptc_out_t res;
  } reading_note_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  bptc_in_t                 in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  bptc_out_t                out_data_o;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i = '0;

  // calibration as the block should currently hold it
  logic [39:0] cal_temp = '0;
  logic [47:0] cal_press_a = '0;
  logic [47:0] cal_press_b = '0;
  logic [31:0] cal_press_c = '0;

  reading_note_t pending_readings[$];
  bptc_out_t     expected_readings[$];

  bit quiet = 1'b0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int n_compensated = 0;
  int n_loads = 0;
  int n_zero_press = 0;
  int n_full_press = 0;
  int n_temp_sat = 0;

  baro_pressure_temp_compensation_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic dir_step_t cfg_row(input cfg_idx_e idx, input logic [47:0] v);
    dir_step_t s;
    s = '{StepCfg, idx, v, '0, 1'b0, '0};
    return s;
  endfunction

  function automatic dir_step_t req_row(input logic [23:0] p, input logic [23:0] t);
    dir_step_t s;
    s = '{StepReq, CfgTempCalib, '0, '{p, t}, 1'b0, '0};
    return s;
  endfunction

  function automatic dir_step_t lit_row(input logic [23:0] p, input logic [23:0] t,
                                        input logic signed [15:0] tc, input logic [23:0] pc);
    dir_step_t s;
    s = '{StepReq, CfgTempCalib, '0, '{p, t}, 1'b1, '{tc, pc}};
    return s;
  endfunction

  // reset calibration gives zero for any reading; then saturation, a sensor-like set,
  // a huge sensitivity, all ones (wrapping intermediates) and every field at its top
  dir_step_t dir_steps [NumDirSteps] = '{
    lit_row(24'h000000, 24'h000000, 16'sd0, 24'd0),
    lit_row(24'hFFFFFF, 24'hFFFFFF, 16'sd0, 24'd0),
    lit_row(24'hFFFFFF, 24'h000000, 16'sd0, 24'd0),
    lit_row(24'h000000, 24'hFFFFFF, 16'sd0, 24'd0),
    cfg_row(CfgTempCalib, 48'h0000_FFFF_0000),
    lit_row(24'h000000, 24'hFFFFFF, TempMax, 24'd0),
    cfg_row(CfgTempCalib, 48'h0000_FFFF_FFFF),
    lit_row(24'h000000, 24'h000000, TempMin, 24'd0),
    cfg_row(CfgTempCalib, 48'h00F9_4A38_6BD0),
    cfg_row(CfgPressCalibA, 48'hFD05_F830_05DC),
    cfg_row(CfgPressCalibB, 48'hFE03_7530_4E20),
    cfg_row(CfgPressCalibC, 48'h0000_FC06_0708),
    req_row(24'h632EA0, 24'h800000),
    req_row(24'h000000, 24'h6BD000),
    req_row(24'hFFFFFF, 24'h800000),
    req_row(24'h400000, 24'hFFFFFF),
    req_row(24'h632EA0, 24'h000000),
    cfg_row(CfgPressCalibA, 48'hFD05_F830_7FFF),
    req_row(24'hFFFFFF, 24'h800000),
    req_row(24'h800000, 24'h800000),
    cfg_row(CfgTempCalib, 48'hFFFF_FFFF_FFFF),
    cfg_row(CfgPressCalibA, 48'hFFFF_FFFF_FFFF),
    cfg_row(CfgPressCalibB, 48'hFFFF_FFFF_FFFF),
    cfg_row(CfgPressCalibC, 48'hFFFF_FFFF_FFFF),
    req_row(24'hFFFFFF, 24'hFFFFFF),
    req_row(24'h000000, 24'h000000),
    req_row(24'h123456, 24'hABCDEF),
    cfg_row(CfgTempCalib, 48'h007F_FFFF_FFFF),
    cfg_row(CfgPressCalibA, 48'h7F7F_7FFF_7FFF),
    cfg_row(CfgPressCalibB, 48'h7F7F_FFFF_FFFF),
    cfg_row(CfgPressCalibC, 48'h0000_7F7F_7FFF),
    req_row(24'hFFFFFF, 24'hFFFFFF),
    req_row(24'h800000, 24'h000000)
  };

  cal_style_e phase_style [NumPhases] = '{CalSensor, CalRandom, CalOnes, CalSensor, CalZeros,
                                         CalRandom, CalSensor, CalSignedMax, CalSensor,
                                         CalSensor};

  function automatic s64_t sext8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic s64_t sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // compensation polynomial, all in wrapping signed 64-bit with truncating divides
  function automatic bptc_out_t compensate(input bptc_in_t req);
    s64_t rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    s64_t d, tl, tc, a, b, c, e, f, g, offset, sens, total;
    logic [63:0] mag, press;
    bptc_out_t res;
    rp = {40'd0, req.raw_pressure};
    rt = {40'd0, req.raw_temperature};
    t1 = {48'd0, cal_temp[15:0]};
    t2 = {48'd0, cal_temp[31:16]};
    t3 = sext8(cal_temp[39:32]);
    p1 = sext16(cal_press_a[15:0]);
    p2 = sext16(cal_press_a[31:16]);
    p3 = sext8(cal_press_a[39:32]);
    p4 = sext8(cal_press_a[47:40]);
    p5 = {48'd0, cal_press_b[15:0]};
    p6 = {48'd0, cal_press_b[31:16]};
    p7 = sext8(cal_press_b[39:32]);
    p8 = sext8(cal_press_b[47:40]);
    p9 = sext16(cal_press_c[15:0]);
    p10 = sext8(cal_press_c[23:16]);
    p11 = sext8(cal_press_c[31:24]);

    // linearised temperature
    d = rt - 64'sd256 * t1;
    a = t2 * d * 64'sd262144;
    b = d * d * t3;
    tl = (a + b) / 64'sd4294967296;
    tc = (tl * 64'sd25) / 64'sd16384;
    if (tc > 64'sd32767) begin
      tc = 64'sd32767;
    end else if (tc < -64'sd32768) begin
      tc = -64'sd32768;
    end

    a = tl * tl;
    b = a / 64'sd64;
    c = (b * tl) / 64'sd256;
    e = (p8 * c) / 64'sd32;
    f = p7 * a * 64'sd16;
    g = p6 * tl * 64'sd4194304;
    offset = p5 * 64'sd140737488355328 + e + f + g;

    b = (p4 * c) / 64'sd32;
    e = p3 * a * 64'sd4;
    f = (p2 - 64'sd16384) * tl * 64'sd2097152;
    sens = (p1 - 64'sd16384) * 64'sd70368744177664 + b + e + f;

    a = (sens / 64'sd16777216) * rp;
    b = p10 * tl;
    c = b + 64'sd65536 * p9;
    e = (c * rp) / 64'sd8192;
    f = (e * rp) / 64'sd512;
    g = rp * rp;
    b = (p11 * g) / 64'sd65536;
    c = (b * rp) / 64'sd128;
    total = offset / 64'sd4 + a + f + c;

    // final scaling done exactly on the split quotient and remainder
    if (total <= 64'sd0) begin
      press = '0;
    end else begin
      mag = total;
      press = (mag >> 40) * 64'd25 + (((mag & 64'hFF_FFFF_FFFF) * 64'd25) >> 40);
      if (press > 64'hFF_FFFF) begin
        press = 64'hFF_FFFF;
      end
    end
    res.temperature_centideg = tc[15:0];
    res.pressure_centipascal = press[23:0];
    return res;
  endfunction

  function automatic logic [7:0] small8(input int m);
    int v;
    v = int'($urandom_range(0, 2 * m)) - m;
    return v[7:0];
  endfunction

  function automatic logic [15:0] small16(input int m);
    int v;
    v = int'($urandom_range(0, 2 * m)) - m;
    return v[15:0];
  endfunction

  // mostly readings near the operating point of the loaded calibration
  function automatic bptc_in_t random_reading();
    bptc_in_t r;
    int unsigned pick;
    int tv;
    pick = $urandom_range(0, 15);
    r.raw_pressure = 24'($urandom);
    r.raw_temperature = 24'($urandom);
    if (pick < 11) begin
      tv = 256 * int'(cal_temp[15:0]) + int'($urandom_range(0, 2000000)) - 700000;
      r.raw_temperature = (tv < 0) ? 24'd0 : (tv > 16777215) ? 24'hFFFFFF : 24'(tv);
      r.raw_pressure = 24'($urandom_range(1000000, 12000000));
    end else if (pick == 11) begin
      r.raw_pressure = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      r.raw_temperature = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    end
    return r;
  endfunction

  task automatic write_calib(input cfg_idx_e idx, input logic [47:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CfgTempCalib:   cal_temp = value[39:0];
      CfgPressCalibA: cal_press_a = value;
      CfgPressCalibB: cal_press_b = value;
      CfgPressCalibC: cal_press_c = value[31:0];
      default: ;
    endcase
    n_loads++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_calib_set(input cal_style_e style);
    logic [47:0] vt, va, vb, vc;
    logic [31:0] junk;
    junk = $urandom;
    case (style)
      CalSensor: begin
        vt = {junk[7:0], small8(8), 16'($urandom_range(16000, 22000)),
              16'($urandom_range(24000, 29000))};
        va = {small8(16), small8(16), small16(4096), small16(4096)};
        vb = {small8(16), small8(16), 16'($urandom_range(24000, 32000)),
              16'($urandom_range(16000, 24000))};
        vc = {junk[23:8], small8(16), small8(16), small16(8192)};
      end
      CalRandom: begin
        vt = {16'($urandom), 32'($urandom)};
        va = {16'($urandom), 32'($urandom)};
        vb = {16'($urandom), 32'($urandom)};
        vc = {16'($urandom), 32'($urandom)};
      end
      CalOnes: begin
        vt = '1;
        va = '1;
        vb = '1;
        vc = '1;
      end
      CalSignedMax: begin
        vt = 48'h007F_FFFF_FFFF;
        va = 48'h7F7F_7FFF_7FFF;
        vb = 48'h7F7F_FFFF_FFFF;
        vc = 48'h0000_7F7F_7FFF;
      end
      default: begin
        vt = '0;
        va = '0;
        vb = '0;
        vc = '0;
      end
    endcase
    write_calib(CfgTempCalib, vt);
    write_calib(CfgPressCalibA, va);
    write_calib(CfgPressCalibB, vb);
    write_calib(CfgPressCalibC, vc);
  endtask

  task automatic send_reading(input bptc_in_t req, input logic known, input bptc_out_t res);
    pending_readings.push_back('{known, res});
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic pause_sender(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // every request is answered, so an empty store means an empty pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0 || expected_readings.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: no progress after %0d cycles", $time, cycle_count);
    $display("tb: failure");
    $finish;
  end

  // receiver stalls in bursts, with long free stretches now and then
  initial begin
    int unsigned len;
    bit hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = !quiet && ($urandom_range(0, 2) == 0);
      if (hold) begin
        len = $urandom_range(1, 10);
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      repeat (len) begin
        @(posedge clk_i);
        out_stall_i <= hold && !quiet;
      end
    end
  end

  always @(posedge clk_i) begin : reading_check
    reading_note_t note;
    bptc_out_t want;
    bptc_out_t got;
    if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: request taken that was never offered", $time);
        mismatch_count++;
      end else begin
        note = pending_readings.pop_front();
        want = note.known ? note.res : compensate(in_data_i);
        expected_readings.push_back(want);
      end
    end
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = out_data_o;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, got temp %0d press %0d", $time,
                 got.temperature_centideg, got.pressure_centipascal);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        n_compensated++;
        if (got.temperature_centideg !== want.temperature_centideg) begin
          $display("%0t: temperature mismatch, expected %0d, got %0d", $time,
                   want.temperature_centideg, got.temperature_centideg);
          mismatch_count++;
        end
        if (got.pressure_centipascal !== want.pressure_centipascal) begin
          $display("%0t: pressure mismatch, expected %0d, got %0d", $time,
                   want.pressure_centipascal, got.pressure_centipascal);
          mismatch_count++;
        end
        if (want.pressure_centipascal == 24'd0) n_zero_press++;
        if (want.pressure_centipascal == PressMax) n_full_press++;
        if (want.temperature_centideg == TempMax || want.temperature_centideg == TempMin) begin
          n_temp_sat++;
        end
      end
    end
  end

  initial begin
    int unsigned gap_den;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == StepCfg) begin
        settle();
        write_calib(dir_steps[i].reg_idx, dir_steps[i].value);
      end else begin
        send_reading(dir_steps[i].req, dir_steps[i].known, dir_steps[i].res);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      // no idling on either side in the closing phase
      quiet = (ph == NumPhases - 1);
      settle();
      load_calib_set(phase_style[ph]);
      gap_den = (quiet || ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 8 : 3;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (gap_den != 0 && $urandom_range(1, gap_den) == 1) begin
          pause_sender($urandom_range(1, 10));
        end
        send_reading(random_reading(), 1'b0, '0);
      end
    end

    settle();
    repeat (3 * NumStages) @(posedge clk_i);
    $display("summary: %0d readings checked over %0d calibration register writes",
             n_compensated, n_loads);
    $display("summary: %0d pressures clamped to zero, %0d at full scale, %0d temps saturated",
             n_zero_press, n_full_press, n_temp_sat);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
